// ===== hw/rtl/string_smallest_period_top_defines.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the smallest string period block
// Shared helpers that wrap concurrent checks on clk and arst_n.
// -----------------------------------------------------------------------------
`ifndef STRING_SMALLEST_PERIOD_TOP_DEFINES_SVH
`define STRING_SMALLEST_PERIOD_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ssp_pkg.sv =====
// -----------------------------------------------------------------------------
// ssp_pkg
// Types and fixed constants shared by the smallest string period block.
// -----------------------------------------------------------------------------
package ssp_pkg;

	localparam int BYTE_W   = 8;
	localparam int PERIOD_W = 7;

	typedef struct packed {
		logic [BYTE_W-1:0] char_code;
		logic              last;
	} ssp_req_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic                overflow;
	} ssp_rsp_t;

	typedef enum logic {
		ST_COLLECT,
		ST_SEARCH
	} ssp_state_t;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic store; // byte enters the chain, live candidates compared
		logic scan;  // candidate flags step one cell toward cell 0
		logic clear; // all candidates valid again
	} ssp_cell_ctl_t;

endpackage

// ===== hw/rtl/ssp_cell.sv =====
// -----------------------------------------------------------------------------
// ssp_cell
// One candidate-period cell: a history byte stage plus a still-valid flag.
// -----------------------------------------------------------------------------
module ssp_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssp_pkg::ssp_cell_ctl_t      ctl,
	input  logic                        live,
	input  logic [ssp_pkg::BYTE_W-1:0]  new_byte,
	input  logic [ssp_pkg::BYTE_W-1:0]  prev_byte,
	input  logic                        flag_in,
	output logic [ssp_pkg::BYTE_W-1:0]  byte_q,
	output logic                        flag_q
);

	logic mismatch;

	// Held byte is history[j-p] for this cell's candidate p.
	assign mismatch = live && (byte_q != new_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b1;
		end else if (ctl.clear) begin
			flag_q <= 1'b1;
		end else if (ctl.store && mismatch) begin
			flag_q <= 1'b0;
		end else if (ctl.scan) begin
			flag_q <= flag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.store) begin
			byte_q <= prev_byte;
		end
	end

endmodule

// ===== hw/rtl/ssp_ctrl.sv =====
// -----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer: byte count, overflow, end-of-string search and result register.
// -----------------------------------------------------------------------------
module ssp_ctrl #(
	parameter int MAX_LEN = 64,
	parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic                   req_last,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output ssp_pkg::ssp_rsp_t      rsp,
	input  logic                   flag0,
	output ssp_pkg::ssp_cell_ctl_t ctl,
	output logic [CNT_W-1:0]       count_q
);

	ssp_pkg::ssp_state_t state_q, state_d;
	logic                too_long_q;
	logic [CNT_W-1:0]    cand_q;
	logic                rsp_valid_q;
	ssp_pkg::ssp_rsp_t   rsp_q;
	logic                accept, store, slot_free, hit, done, scan;

	assign accept    = req_valid && req_ready;
	assign store     = accept && (count_q < CNT_W'(MAX_LEN));
	assign slot_free = !rsp_valid_q || rsp_ready;
	// Stop on overflow, on a surviving candidate, or when candidates run out.
	assign hit       = too_long_q || (cand_q >= count_q) || flag0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssp_pkg::ST_COLLECT: begin
				if (accept && req_last) begin
					state_d = ssp_pkg::ST_SEARCH;
				end
			end
			ssp_pkg::ST_SEARCH: begin
				if (hit && slot_free) begin
					state_d = ssp_pkg::ST_COLLECT;
				end
			end
			default: state_d = ssp_pkg::ST_COLLECT;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		done      = 1'b0;
		scan      = 1'b0;
		unique case (state_q)
			ssp_pkg::ST_COLLECT: req_ready = 1'b1;
			ssp_pkg::ST_SEARCH: begin
				done = hit && slot_free;
				scan = !hit;
			end
			default: req_ready = 1'b0;
		endcase
	end

	assign ctl.store = store;
	assign ctl.scan  = scan;
	assign ctl.clear = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssp_pkg::ST_COLLECT;
			count_q     <= '0;
			too_long_q  <= 1'b0;
			cand_q      <= CNT_W'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (done) begin
				count_q <= '0;
			end else if (store) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (done) begin
				too_long_q <= 1'b0;
			end else if (accept && !store) begin
				too_long_q <= 1'b1;
			end

			if (state_q == ssp_pkg::ST_COLLECT) begin
				cand_q <= CNT_W'(1);
			end else if (scan) begin
				cand_q <= cand_q + CNT_W'(1);
			end

			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Candidate counter equals n when no shorter period survived.
	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q.overflow <= too_long_q;
			rsp_q.period   <= too_long_q ? '0 : ssp_pkg::PERIOD_W'(cand_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/string_smallest_period_top.sv =====
// -----------------------------------------------------------------------------
// string_smallest_period_top
// Smallest repeating period of a byte string streamed one request at a time.
// -----------------------------------------------------------------------------
// Each request carries one byte; the request with last set closes the string
// and produces one response holding the smallest period p (1..n), or
// overflow = 1 with period = 0 when the string ran past MAX_LEN bytes.
// Bytes are taken one per cycle while a string is collected (req_ready is low
// during the search): each enters a chain of MAX_LEN cells, where cell k holds
// the byte seen k+1 bytes ago and the flag for period k+1, so all candidates
// are checked in the same cycle. After the last byte the flags step through
// the chain toward cell 0, one candidate per cycle, up to candidate p (n when
// no shorter period holds; no step on overflow), and the search also waits
// while the previous response waits for rsp_ready; then the response is
// registered and the next string may start. A waiting response does not hold
// off the bytes of the next string. No clearing pass follows reset.
// -----------------------------------------------------------------------------
module string_smallest_period_top #(
	parameter int MAX_LEN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ssp_pkg::ssp_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ssp_pkg::ssp_rsp_t rsp
);

	localparam int CNT_W = $clog2(MAX_LEN + 1);

	ssp_pkg::ssp_cell_ctl_t        ctl;
	logic [CNT_W-1:0]              count;
	logic [ssp_pkg::BYTE_W-1:0]    hist [MAX_LEN];
	logic [MAX_LEN-1:0]            flags;

	// Sequencer: length, overflow, end-of-string search, response register
	ssp_ctrl #(
		.MAX_LEN (MAX_LEN),
		.CNT_W   (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_last  (req.last),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.flag0     (flags[0]),
		.ctl       (ctl),
		.count_q   (count)
	);

	// Cell k: candidate period k+1. Its byte is only compared once the string
	// has reached k+1 bytes, so stale history never matters.
	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		logic [ssp_pkg::BYTE_W-1:0] prev;
		logic                       nbr_flag;
		logic                       live;

		if (k == 0) begin : g_head
			assign prev = req.char_code;
		end else begin : g_body
			assign prev = hist[k-1];
		end

		// Ones shift in at the far end during the search.
		if (k == MAX_LEN - 1) begin : g_tail
			assign nbr_flag = 1'b1;
		end else begin : g_link
			assign nbr_flag = flags[k+1];
		end

		assign live = count > CNT_W'(k);

		ssp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.live      (live),
			.new_byte  (req.char_code),
			.prev_byte (prev),
			.flag_in   (nbr_flag),
			.byte_q    (hist[k]),
			.flag_q    (flags[k])
		);
	end

endmodule

// ===== hw/rtl/ssp_checker.sv =====
// -----------------------------------------------------------------------------
// ssp_checker
// Port-level checks on the smallest string period block, bound to the top.
// -----------------------------------------------------------------------------
`include "string_smallest_period_top_defines.svh"

module ssp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input ssp_pkg::ssp_req_t req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input ssp_pkg::ssp_rsp_t rsp
);

	`SSP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response dropped or changed while stalled")
	`SSP_ASSERT_NXT(a_last_stalls, req_valid && req_ready && req.last, !req_ready, "request taken right after last byte")
	`SSP_ASSERT_IMP(a_ovf_period, rsp_valid && rsp.overflow, rsp.period == '0, "overflow response with nonzero period")
	`SSP_ASSERT_IMP(a_period_pos, rsp_valid && !rsp.overflow, rsp.period != '0, "zero period without overflow")

endmodule

bind string_smallest_period_top ssp_checker u_ssp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
